// ===== design/egcd_pkg.sv =====
// Shared types for the extended Euclid unit.
`default_nettype none

package egcd_pkg;

  // One quotient bit leaving the serial divider, MSB first
  typedef struct packed {
    logic valid;  // a quotient bit is present this cycle
    logic qbit;   // the quotient bit itself
    logic last;   // least significant quotient bit of this division
  } egcd_qbit_t;

endpackage : egcd_pkg

`default_nettype wire

// ===== design/egcd_div.sv =====
// Restoring divider that yields one quotient bit per cycle, MSB first.
`default_nettype none

module egcd_div #(
  parameter int unsigned W = 31
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  logic [W-1:0]         dividend_i,
  input  logic [W-1:0]         divisor_i,
  output egcd_pkg::egcd_qbit_t qbit_o,
  output logic [W-1:0]         rem_o
);
  import egcd_pkg::*;

  localparam int unsigned CntW = $clog2(W);

  logic [W-1:0]    dvd_q, dvd_d;
  logic [W-1:0]    dsr_q, dsr_d;
  logic [W-1:0]    rem_q, rem_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            active_q, active_d;
  logic [W:0]      trial;
  logic [W:0]      diff;
  logic            fits;
  logic            last;

  // Trial subtract of the divisor from the shifted partial remainder
  assign trial = {rem_q, dvd_q[W-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign fits  = ~diff[W];
  assign last  = (cnt_q == '0);

  // Advance one dividend bit per cycle while active
  always_comb begin
    dvd_d    = dvd_q;
    dsr_d    = dsr_q;
    rem_d    = rem_q;
    cnt_d    = cnt_q;
    active_d = active_q;
    if (load_i) begin
      dvd_d    = dividend_i;
      dsr_d    = divisor_i;
      rem_d    = '0;
      cnt_d    = CntW'(W - 1);
      active_d = 1'b1;
    end else if (active_q) begin
      dvd_d = {dvd_q[W-2:0], 1'b0};
      rem_d = fits ? diff[W-1:0] : trial[W-1:0];
      cnt_d = cnt_q - CntW'(1);
      if (last) begin
        active_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      cnt_q    <= cnt_d;
    end
  end

  // Datapath registers hold no reset
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dsr_q <= dsr_d;
    rem_q <= rem_d;
  end

  assign qbit_o.valid = active_q;
  assign qbit_o.qbit  = active_q & fits;
  assign qbit_o.last  = active_q & last;
  assign rem_o        = rem_q;

endmodule : egcd_div

`default_nettype wire

// ===== design/egcd_macc.sv =====
// Serial multiplier: builds quotient times coefficient from MSB-first quotient bits.
`default_nettype none

module egcd_macc #(
  parameter int unsigned CW = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 clear_i,
  input  egcd_pkg::egcd_qbit_t qbit_i,
  input  logic [CW-1:0]        coef_i,
  output logic [CW-1:0]        prod_o
);
  import egcd_pkg::*;

  logic [CW-1:0] acc_q, acc_d;

  // Horner step: double and add the coefficient when the bit is set
  always_comb begin
    acc_d = acc_q;
    if (clear_i) begin
      acc_d = '0;
    end else if (qbit_i.valid) begin
      acc_d = {acc_q[CW-2:0], 1'b0} + (qbit_i.qbit ? coef_i : '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign prod_o = acc_q;

endmodule : egcd_macc

`default_nettype wire

// ===== design/extended_gcd_unit.sv =====
// Top level of the extended Euclid unit: step sequencer and result register.
//
// Usage: drive first_operand_i and second_operand_i and raise start while
// busy is low; the beat is taken at that clock edge and busy rises. The unit
// returns gcd g on divisor_o and Bezout coefficients p, q on coef_first_o and
// coef_second_o (two's complement, a*p + b*q = g), marked by done_o for
// exactly one cycle. The receiver cannot stall; the result is simply shown
// for that one cycle and then dropped from the strobe.
// Each Euclid step runs a zero test, then the quotient bits, one per cycle
// from the serial divider, then a coefficient update. busy is already low in
// the cycle done_o is high, so the next beat may be taken at the edge that
// ends the result cycle.
// Reset returns the unit to idle and drops done_o; nothing is kept between
// items.
`default_nettype none

module extended_gcd_unit #(
  parameter int unsigned OPERAND_BITS = 31
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [OPERAND_BITS-1:0]        first_operand_i,
  input  logic [OPERAND_BITS-1:0]        second_operand_i,
  output logic                           done_o,
  output logic [OPERAND_BITS-1:0]        divisor_o,
  output logic signed [OPERAND_BITS:0]   coef_first_o,
  output logic signed [OPERAND_BITS:0]   coef_second_o
);
  import egcd_pkg::*;

  localparam int unsigned W  = OPERAND_BITS;
  localparam int unsigned CW = OPERAND_BITS + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_TEST,
    S_DIV,
    S_UPD
  } state_e;

  state_e        state_q;
  logic [W-1:0]  r_prev_q, r_cur_q;
  logic [CW-1:0] s_prev_q, s_cur_q;
  logic [CW-1:0] t_prev_q, t_cur_q;
  logic          done_q;
  logic [W-1:0]  g_q;
  logic [CW-1:0] p_q, q_q;

  logic          div_load;
  egcd_qbit_t    qbit;
  logic [W-1:0]  rem;
  logic [CW-1:0] s_prod, t_prod;
  logic          accept;

  assign accept   = start && !busy;
  assign div_load = (state_q == S_TEST) && (r_cur_q != '0);

  // Serial divider for the step quotient and remainder
  egcd_div #(
    .W (W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (div_load),
    .dividend_i (r_prev_q),
    .divisor_i  (r_cur_q),
    .qbit_o     (qbit),
    .rem_o      (rem)
  );

  // Quotient times current coefficients, built alongside the division
  egcd_macc #(
    .CW (CW)
  ) u_macc_s (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (div_load),
    .qbit_i  (qbit),
    .coef_i  (s_cur_q),
    .prod_o  (s_prod)
  );

  egcd_macc #(
    .CW (CW)
  ) u_macc_t (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (div_load),
    .qbit_i  (qbit),
    .coef_i  (t_cur_q),
    .prod_o  (t_prod)
  );

  // Sequence the Euclid steps and register the result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      done_q   <= 1'b0;
      r_prev_q <= '0;
      r_cur_q  <= '0;
      s_prev_q <= '0;
      s_cur_q  <= '0;
      t_prev_q <= '0;
      t_cur_q  <= '0;
      g_q      <= '0;
      p_q      <= '0;
      q_q      <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            r_prev_q <= first_operand_i;
            r_cur_q  <= second_operand_i;
            s_prev_q <= CW'(1);
            s_cur_q  <= '0;
            t_prev_q <= '0;
            t_cur_q  <= CW'(1);
            state_q  <= S_TEST;
          end
        end
        S_TEST: begin
          if (r_cur_q == '0) begin
            g_q     <= r_prev_q;
            p_q     <= s_prev_q;
            q_q     <= t_prev_q;
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (qbit.last) begin
            state_q <= S_UPD;
          end
        end
        S_UPD: begin
          r_prev_q <= r_cur_q;
          r_cur_q  <= rem;
          s_prev_q <= s_cur_q;
          s_cur_q  <= s_prev_q - s_prod;
          t_prev_q <= t_cur_q;
          t_cur_q  <= t_prev_q - t_prod;
          state_q  <= S_TEST;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy          = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign divisor_o     = g_q;
  assign coef_first_o  = p_q;
  assign coef_second_o = q_q;

  // A result only appears once the sequencer is back to idle
  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  // An accepted beat always makes the unit busy
  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("accepted beat did not start the unit");

  // Division never runs with a zero divisor
  a_div_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (r_cur_q != '0))
    else $error("division with zero divisor");

  // Quotient bits only stream during the division phase
  a_qbit_in_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    qbit.valid |-> (state_q == S_DIV))
    else $error("quotient bit outside division");

  // The remainder handed to the next step is below its divisor
  a_rem_below : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UPD) |-> (rem < r_cur_q))
    else $error("remainder not below divisor");

endmodule : extended_gcd_unit

`default_nettype wire
